[hdl/assert_macros.svh]
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: label");

// Check a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: label");

`endif

[hdl/brlc_pkg.sv]
// Package: types, codes and helpers of the bit-reservoir level checker.
`timescale 1ns / 1ps

package brlc_pkg;

    // Field widths
    localparam int OP_W       = 2;
    localparam int MDB_W      = 9;
    localparam int FLEN_W     = 11;
    localparam int P23_W      = 14;
    localparam int CREDIT_W   = 11;
    localparam int LOAD_W     = 12;
    localparam int LEVEL_W    = 12;
    localparam int SIDE_W     = 6;
    localparam int CAP_W      = 9;
    localparam int OVH_W      = 7;
    localparam int SUM_W      = 15;

    // Stream and configuration port widths
    localparam int S_TDATA_W  = 64;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // Fixed frame header size in bytes
    localparam logic [OVH_W-1:0] HEADER_BYTES = 7'd4;

    // Register reset values
    localparam logic [SIDE_W-1:0] SIDE_INFO_RESET = 6'd17;
    localparam logic [CAP_W-1:0]  RES_CAP_RESET   = 9'd511;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_INFO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_CAP   = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_HEAD_CREDIT = 2'd0,
        OP_FRAME       = 2'd1,
        OP_TAIL_CREDIT = 2'd2,
        OP_LOAD        = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [MDB_W-1:0]    main_data_begin;
        logic [FLEN_W-1:0]   frame_bytes;
        logic [P23_W-1:0]    part23_bits;
        logic [CREDIT_W-1:0] credit_bytes;
        logic                tail_partial;
        logic [LOAD_W-1:0]   load_value;
    } brlc_item_t;

    typedef struct packed {
        logic [SIDE_W-1:0] side_info_bytes;
        logic [CAP_W-1:0]  reservoir_cap_bytes;
    } brlc_cfg_t;

    typedef struct packed {
        logic               ok;
        logic [LEVEL_W-1:0] level_bits;
    } brlc_result_t;

    // Clamp a widened level at the cap in bits
    function automatic logic [LEVEL_W-1:0] clamp_cap(input logic [SUM_W-1:0] v,
                                                     input logic [LEVEL_W-1:0] cap_bits);
        logic [LEVEL_W-1:0] r;
        if (v > {3'b000, cap_bits})
            r = cap_bits;
        else
            r = v[LEVEL_W-1:0];
        return r;
    endfunction

endpackage

[hdl/brlc_step.sv]
// Next-level and check logic for one item against the current reservoir level.
`timescale 1ns / 1ps

module brlc_step
    import brlc_pkg::*;
(
    input  brlc_item_t         item,
    input  brlc_cfg_t          cfg,
    input  logic [LEVEL_W-1:0] level,
    output brlc_result_t       res
);

    logic [OVH_W-1:0]    overhead;
    logic [LEVEL_W-1:0]  cap_bits;
    logic [SUM_W-1:0]    head_sum;
    logic                ptr_fail;
    logic                has_payload;
    logic [FLEN_W-1:0]   payload_bytes;
    logic [P23_W-1:0]    produced;
    logic [SUM_W-1:0]    avail;
    logic                short_fail;
    logic [SUM_W-1:0]    frame_left;
    logic                tail_ok;
    logic [CREDIT_W-1:0] tail_bytes;
    logic [SUM_W-1:0]    tail_sum;

    // Shared terms
    assign overhead = {1'b0, cfg.side_info_bytes} + HEADER_BYTES;
    assign cap_bits = {cfg.reservoir_cap_bytes, 3'b000};

    // Head credit sum
    assign head_sum = {3'b000, level} + {1'b0, item.credit_bytes, 3'b000};

    // Frame: back-pointer check, payload and bits left
    assign ptr_fail      = item.main_data_begin > level[LEVEL_W-1:3];
    assign has_payload   = item.frame_bytes > {4'b0000, overhead};
    assign payload_bytes = item.frame_bytes - {4'b0000, overhead};
    assign produced      = has_payload ? {payload_bytes, 3'b000} : '0;
    assign avail         = {3'b000, item.main_data_begin, 3'b000} + {1'b0, produced};
    assign short_fail    = {1'b0, item.part23_bits} > avail;
    assign frame_left    = avail - {1'b0, item.part23_bits};

    // Tail credit of a partial frame
    assign tail_ok    = item.tail_partial && (item.credit_bytes > {4'b0000, overhead});
    assign tail_bytes = item.credit_bytes - {4'b0000, overhead};
    assign tail_sum   = {3'b000, level} + {1'b0, tail_bytes, 3'b000};

    // Select by item kind
    always_comb
    begin
        res.ok         = 1'b1;
        res.level_bits = level;
        unique case (item.op)
            OP_HEAD_CREDIT:
            begin
                if (item.credit_bytes != '0)
                    res.level_bits = clamp_cap(head_sum, cap_bits);
            end
            OP_FRAME:
            begin
                if (ptr_fail || short_fail)
                    res.ok = 1'b0;
                else
                    res.level_bits = clamp_cap(frame_left, cap_bits);
            end
            OP_TAIL_CREDIT:
            begin
                if (tail_ok)
                    res.level_bits = clamp_cap(tail_sum, cap_bits);
            end
            OP_LOAD:
            begin
                res.level_bits = item.load_value;
            end
            default:
            begin
                res.level_bits = level;
            end
        endcase
    end

endmodule

[hdl/bit_reservoir_level_checker_unit.sv]
// Top level of the MP3 Layer III bit-reservoir level checker.
//
//   channel  direction  handshake            payload
//   s_       in         s_tvalid / s_tready  s_tdata item fields, s_tuser op
//   m_       out        m_tvalid / m_tready  m_tdata level_bits, m_tuser ok
//   cfg_     in         cfg_we               cfg_index, cfg_data
//
// One item per cycle while results are taken: the level loop closes on level_reg alone.
// A result passes the input register, then the output register, before it is shown.
// Reset clears the level to zero and loads register defaults (side info 17, cap 511).
// A stalled result holds the output register; the input register still takes one
// more item, then s_tready drops until the result is taken.
`timescale 1ns / 1ps

module bit_reservoir_level_checker_unit
    import brlc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [8:0] main_data_begin, [19:9] frame_bytes, [33:20] part23_bits,
    // [44:34] credit_bytes, [45] tail_partial, [57:46] load_value, [63:58] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] op
    input  logic [S_TUSER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [11:0] level_bits, [15:12] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [0] ok
    output logic [M_TUSER_W-1:0]  m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    brlc_item_t         s_item;
    brlc_item_t         in_item_reg;
    logic               in_valid_reg;
    logic               in_advance;
    brlc_cfg_t          cfg_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    brlc_result_t       step_res;
    brlc_result_t       out_res_reg;
    logic               out_valid_reg;

    // Unpack the incoming transfer
    always_comb
    begin
        s_item.op              = op_t'(s_tuser[1:0]);
        s_item.main_data_begin = s_tdata[8:0];
        s_item.frame_bytes     = s_tdata[19:9];
        s_item.part23_bits     = s_tdata[33:20];
        s_item.credit_bytes    = s_tdata[44:34];
        s_item.tail_partial    = s_tdata[45];
        s_item.load_value      = s_tdata[57:46];
    end

    // Advance the held item when the output register is free or draining
    assign in_advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || in_advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= s_item;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.side_info_bytes     <= SIDE_INFO_RESET;
            cfg_reg.reservoir_cap_bytes <= RES_CAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIDE_INFO: cfg_reg.side_info_bytes     <= cfg_data[SIDE_W-1:0];
                CFG_RES_CAP:   cfg_reg.reservoir_cap_bytes <= cfg_data[CAP_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Step logic
    brlc_step u_step (
        .item  (in_item_reg),
        .cfg   (cfg_reg),
        .level (level_reg),
        .res   (step_res)
    );

    assign level_next = step_res.level_bits;

    // Level register: update on each item that moves to the output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= '0;
        else if (in_advance)
            level_reg <= level_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_advance)
            out_res_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-LEVEL_W){1'b0}}, out_res_reg.level_bits};
    assign m_tuser  = out_res_reg.ok;

endmodule

[hdl/brlc_checker.sv]
// Port-level checker for the bit-reservoir level checker, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brlc_checker
    import brlc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    logic [LEVEL_W-1:0] last_level_reg;

    // Track the level shown by the last result transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_level_reg <= '0;
        else if (m_tvalid && m_tready)
            last_level_reg <= m_tdata[LEVEL_W-1:0];
    end

    // A stalled result holds its data
    `ASSERT_CLK(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // A failed frame leaves the level as the previous result showed it
    `ASSERT_CLK(a_fail_keeps_level, clk, rst_n, m_tvalid && m_tready && !m_tuser[0] |-> m_tdata[LEVEL_W-1:0] == last_level_reg)

    // Padding above the level stays zero
    `ASSERT_CLK(a_pad_zero, clk, rst_n, m_tvalid |-> m_tdata[M_TDATA_W-1:LEVEL_W] == '0)

    // A draining output always lets the input side move
    `ASSERT_ALWAYS(a_ready_follows, clk, m_tready |-> s_tready)

endmodule

bind bit_reservoir_level_checker_unit brlc_checker u_brlc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

[bench/bit_reservoir_level_checker_unit_test.sv]
// Self-checking bench for the bit-reservoir level checker: stream stimulus and level tracking.
`timescale 1ns / 1ps

module bit_reservoir_level_checker_unit_test;
    import brlc_pkg::*;

    localparam int HALF_PERIOD_NS  = 10;
    localparam int RESET_CYCLES    = 4;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int TIMEOUT_NS      = 4_000_000;

    // Tracks the reservoir level and queues the result each transfer should produce
    class level_tracker;
        logic [SIDE_W-1:0]  side_info;
        logic [CAP_W-1:0]   cap_bytes;
        logic [LEVEL_W-1:0] level;
        brlc_result_t       expected_q[$];
        int                 errors;
        int                 checked;
        int                 rejected;
        int                 op_seen[4];

        function new();
            side_info = SIDE_INFO_RESET;
            cap_bytes = RES_CAP_RESET;
            level     = '0;
            errors    = 0;
            checked   = 0;
            rejected  = 0;
            foreach (op_seen[i])
                op_seen[i] = 0;
        endfunction

        function int clamp_to_cap(int v);
            int cap_bits;
            cap_bits = int'(cap_bytes) * 8;
            return (v > cap_bits) ? cap_bits : v;
        endfunction

        // Advance the level for one accepted item and queue its result
        function void note_transfer(brlc_item_t it);
            int overhead;
            int produced;
            int avail;
            int next_level;
            brlc_result_t res;
            res.ok     = 1'b1;
            next_level = int'(level);
            overhead   = int'(HEADER_BYTES) + int'(side_info);
            op_seen[int'(it.op)]++;
            case (it.op)
                OP_HEAD_CREDIT:
                begin
                    if (it.credit_bytes != '0)
                        next_level = clamp_to_cap(int'(level) + int'(it.credit_bytes) * 8);
                end
                OP_FRAME:
                begin
                    if (int'(it.main_data_begin) > int'(level) / 8)
                        res.ok = 1'b0;
                    else
                    begin
                        produced = (int'(it.frame_bytes) > overhead) ?
                                   (int'(it.frame_bytes) - overhead) * 8 : 0;
                        avail = int'(it.main_data_begin) * 8 + produced;
                        if (int'(it.part23_bits) > avail)
                            res.ok = 1'b0;
                        else
                            next_level = clamp_to_cap(avail - int'(it.part23_bits));
                    end
                end
                OP_TAIL_CREDIT:
                begin
                    if (it.tail_partial && int'(it.credit_bytes) > overhead)
                        next_level = clamp_to_cap(int'(level) +
                                                  (int'(it.credit_bytes) - overhead) * 8);
                end
                default:
                    next_level = int'(it.load_value);
            endcase
            level          = LEVEL_W'(next_level);
            res.level_bits = level;
            expected_q.insert(expected_q.size(), res);
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_result(logic ok, logic [LEVEL_W-1:0] level_bits);
            brlc_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected: ok %0b level_bits %0d",
                         $time, ok, level_bits);
                return;
            end
            exp_res = expected_q.pop_front();
            checked++;
            if (!exp_res.ok)
                rejected++;
            if (ok !== exp_res.ok)
            begin
                errors++;
                $display("%0t: ok mismatch, expected %0b, actual %0b",
                         $time, exp_res.ok, ok);
            end
            if (level_bits !== exp_res.level_bits)
            begin
                errors++;
                $display("%0t: level_bits mismatch, expected %0d, actual %0d",
                         $time, exp_res.level_bits, level_bits);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [S_TUSER_W-1:0]  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    level_tracker tracker;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           hold_request  = 1'b0;
    int           settings_used = 0;

    bit_reservoir_level_checker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD_NS clk = ~clk;

    function automatic brlc_item_t item_of(op_t op, int mdb, int flen, int p23, int credit,
                                           bit partial, int load);
        brlc_item_t it;
        it.op              = op;
        it.main_data_begin = MDB_W'(mdb);
        it.frame_bytes     = FLEN_W'(flen);
        it.part23_bits     = P23_W'(p23);
        it.credit_bytes    = CREDIT_W'(credit);
        it.tail_partial    = partial;
        it.load_value      = LOAD_W'(load);
        return it;
    endfunction

    // Mostly well-formed frames and credits around the current level, with some noise
    function automatic brlc_item_t random_item();
        brlc_item_t it;
        int kind;
        int held;
        int overhead;
        int mdb;
        int flen;
        int avail;
        int slack;
        int p23;
        it = item_of(op_t'($urandom_range(0, 3)), $urandom_range(0, 511),
                     $urandom_range(0, 2047), $urandom_range(0, 16383),
                     $urandom_range(0, 2047), $urandom_range(0, 1), $urandom_range(0, 4095));
        overhead = int'(HEADER_BYTES) + int'(tracker.side_info);
        held     = int'(tracker.level) / 8;
        kind     = $urandom_range(0, 99);
        if (kind < 45)
        begin
            it.op = OP_FRAME;
            if ($urandom_range(0, 99) < 85)
                mdb = $urandom_range(0, held);
            else
                mdb = held + $urandom_range(1, 16);
            if (mdb > 511)
                mdb = 511;
            if ($urandom_range(0, 9) < 8)
                flen = $urandom_range(overhead, overhead + 420);
            else
                flen = $urandom_range(0, 2047);
            avail = mdb * 8 + ((flen > overhead) ? (flen - overhead) * 8 : 0);
            if ($urandom_range(0, 9) < 8)
            begin
                slack = $urandom_range(0, 700);
                p23   = (avail > slack) ? avail - slack : 0;
            end
            else
                p23 = avail + $urandom_range(1, 40);
            if (p23 > 16383)
                p23 = 16383;
            it.main_data_begin = MDB_W'(mdb);
            it.frame_bytes     = FLEN_W'(flen);
            it.part23_bits     = P23_W'(p23);
        end
        else if (kind < 65)
        begin
            it.op = OP_HEAD_CREDIT;
            if ($urandom_range(0, 99) < 80)
                it.credit_bytes = CREDIT_W'($urandom_range(0, 40));
        end
        else if (kind < 80)
        begin
            it.op           = OP_TAIL_CREDIT;
            it.tail_partial = ($urandom_range(0, 99) < 75);
            if ($urandom_range(0, 99) < 75)
                it.credit_bytes = CREDIT_W'($urandom_range(0, overhead + 60));
        end
        else if (kind < 90)
            it.op = OP_LOAD;
        return it;
    endfunction

    // Offer one item, with a random gap first, and hold it until the transfer
    task automatic send_item(input brlc_item_t it);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, it.load_value, it.tail_partial, it.credit_bytes,
                     it.part23_bits, it.frame_bytes, it.main_data_begin};
        s_tuser  <= it.op;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_transfer(it);
    endtask

    // Stop offering and wait for every outstanding result, then let the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Drain, write both registers, then run a batch of random items
    task automatic run_phase(input logic [CFG_DATA_W-1:0] side_data,
                             input logic [CFG_DATA_W-1:0] cap_data,
                             input int send_pct, input int recv_pct, input int count,
                             input bit hold_off, input bit pause_midway);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SIDE_INFO;
        cfg_data  <= side_data;
        tracker.side_info = side_data[SIDE_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_RES_CAP;
        cfg_data  <= cap_data;
        tracker.cap_bytes = cap_data[CAP_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (hold_off)
            hold_request = 1'b1;
        for (int i = 0; i < count; i++)
        begin
            if (pause_midway && i == count / 2)
                wait_drained();
            send_item(random_item());
        end
    endtask

    // Result side: check each transfer, stall at random or for one long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tuser[0], m_tdata[LEVEL_W-1:0]);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
                m_tready     <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Stimulus: reset, directed items under default registers, then random phases
    initial
    begin
        tracker   = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_SIDE_INFO;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 37;
        recv_idle_pct = 78;
        settings_used = 1;
        // empty reservoir, zero credit, back-pointer past an empty reservoir
        send_item(item_of(OP_FRAME, 0, 0, 0, 0, 1'b0, 0));
        send_item(item_of(OP_HEAD_CREDIT, 0, 0, 0, 0, 1'b0, 0));
        send_item(item_of(OP_FRAME, 1, 2047, 0, 0, 1'b0, 0));
        // saturate at the cap, frame at the deepest back-pointer
        send_item(item_of(OP_HEAD_CREDIT, 0, 0, 0, 2047, 1'b0, 0));
        send_item(item_of(OP_FRAME, 511, 2047, 0, 0, 1'b0, 0));
        // consumption beyond what is available, then an exact drain to zero
        send_item(item_of(OP_FRAME, 511, 21, 16383, 0, 1'b0, 0));
        send_item(item_of(OP_FRAME, 10, 22, 88, 0, 1'b0, 0));
        send_item(item_of(OP_HEAD_CREDIT, 0, 0, 0, 1, 1'b0, 0));
        send_item(item_of(OP_FRAME, 1, 2047, 16383, 0, 1'b0, 0));
        send_item(item_of(OP_FRAME, 1, 2047, 16216, 0, 1'b0, 0));
        // level above the cap survives a zero credit, then gets clamped
        send_item(item_of(OP_LOAD, 0, 0, 0, 0, 1'b0, 4095));
        send_item(item_of(OP_HEAD_CREDIT, 0, 0, 0, 0, 1'b0, 0));
        send_item(item_of(OP_FRAME, 511, 100, 0, 0, 1'b0, 0));
        send_item(item_of(OP_LOAD, 0, 0, 0, 0, 1'b0, 4095));
        send_item(item_of(OP_TAIL_CREDIT, 0, 0, 0, 22, 1'b1, 0));
        // tail credit: not partial, exactly the overhead, then saturating
        send_item(item_of(OP_LOAD, 0, 0, 0, 0, 1'b0, 7));
        send_item(item_of(OP_TAIL_CREDIT, 0, 0, 0, 2047, 1'b0, 0));
        send_item(item_of(OP_TAIL_CREDIT, 0, 0, 0, 21, 1'b1, 0));
        send_item(item_of(OP_TAIL_CREDIT, 0, 0, 0, 2047, 1'b1, 0));
        // alternating load patterns and all-ones fields on unused slots
        send_item(item_of(OP_LOAD, 0, 0, 0, 0, 1'b0, 12'hAAA));
        send_item(item_of(OP_LOAD, 0, 0, 0, 0, 1'b0, 12'h555));
        send_item(item_of(OP_HEAD_CREDIT, 0, 0, 0, 5, 1'b0, 0));
        send_item(item_of(OP_LOAD, 511, 2047, 16383, 2047, 1'b1, 4088));
        send_item(item_of(OP_HEAD_CREDIT, 511, 2047, 16383, 0, 1'b1, 4095));

        run_phase(9'd32, 9'd511, 37, 78, 110, 1'b0, 1'b0);
        run_phase(9'd9, 9'd255, 78, 37, 110, 1'b0, 1'b0);
        // side info 17 with the upper data bits set, zero capacity
        run_phase(9'h1D1, 9'd0, 78, 37, 60, 1'b0, 1'b0);
        run_phase(9'h03F, 9'd1, 0, 0, 60, 1'b1, 1'b0);
        // side info 0 through masked upper bits
        run_phase(9'h1C0, 9'd300, 0, 0, 90, 1'b0, 1'b1);
        run_phase(9'd17, 9'd511, 0, 0, 110, 1'b0, 1'b0);

        wait_drained();
        $display("Checked %0d results under %0d register settings (%0d frames rejected).",
                 tracker.checked, settings_used, tracker.rejected);
        $display("Items by kind: head %0d, frame %0d, tail %0d, load %0d.",
                 tracker.op_seen[OP_HEAD_CREDIT], tracker.op_seen[OP_FRAME],
                 tracker.op_seen[OP_TAIL_CREDIT], tracker.op_seen[OP_LOAD]);
        if (tracker.errors == 0 && tracker.expected_q.size() == 0)
            $display("** bit_reservoir_level_checker_unit: PASSED **");
        else
            $display("** bit_reservoir_level_checker_unit: FAILED **");
        $finish;
    end

    // Abort a hung run
    initial
    begin
        #TIMEOUT_NS;
        $display("Timeout with %0d results outstanding.", tracker.expected_q.size());
        $display("** bit_reservoir_level_checker_unit: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/brlc_pkg.sv
hdl/brlc_step.sv
hdl/bit_reservoir_level_checker_unit.sv
hdl/brlc_checker.sv
bench/bit_reservoir_level_checker_unit_test.sv
